@@ rtl/core/csl_pkg.sv @@
// Package for the cross stencil low-pass filter: frame geometry constants,
// payload structs of both channels and the window bundle between submodules.
// No dependencies.
package csl_pkg;

	localparam int LINE_WIDTH   = 160;
	localparam int FRAME_PIXELS = 19200;

	localparam int PIX_W   = 5;
	localparam int RAW_W   = 16;
	localparam int INDEX_W = 15;
	localparam int RGB_W   = 3 * PIX_W;

	// The line holds the 2*LINE_WIDTH pixels before the current one.
	localparam int LINE_DEPTH = 2 * LINE_WIDTH;
	localparam int CNT_W      = $clog2(FRAME_PIXELS + 1);

	localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_PIXELS);
	localparam logic [CNT_W-1:0] FIRST_CNT = CNT_W'(2 * LINE_WIDTH);
	localparam logic [CNT_W-1:0] ROW_CNT   = CNT_W'(LINE_WIDTH);

	typedef struct packed {
		logic [RAW_W-1:0] pixel_in;
		logic             frame_start;
	} pix_t;

	typedef struct packed {
		logic [INDEX_W-1:0] out_index;
		logic [RGB_W-1:0]   out_rgb;
	} res_t;

	// Neighborhood of one centre pixel, plus whether it yields a result.
	typedef struct packed {
		logic               produce;
		logic [INDEX_W-1:0] index;
		logic [PIX_W-1:0]   up;
		logic [PIX_W-1:0]   left;
		logic [PIX_W-1:0]   centre;
		logic [PIX_W-1:0]   right;
		logic [PIX_W-1:0]   down;
	} win_t;

endpackage

@@ rtl/core/csl_window.sv @@
// Pixel delay line and frame index counter of the cross stencil filter.
// Presents the five-point neighborhood of the centre pixel for the incoming pixel.
// Depends on csl_pkg.
module csl_window import csl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  pix_t pix,
	output win_t win
);

	logic [PIX_W-1:0] line_q [LINE_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx;
	logic [CNT_W-1:0] centre_idx;
	logic [PIX_W-1:0] down;

	assign down       = pix.pixel_in[PIX_W-1:0];
	assign idx        = pix.frame_start ? '0 : count_q;
	assign centre_idx = idx - ROW_CNT;

	// Entry k of the line holds the pixel accepted k+1 transactions ago, so the
	// taps are read one place earlier than they sit after the shift.
	always_comb begin
		win.produce = (idx >= FIRST_CNT) && (idx < FRAME_CNT);
		win.index   = INDEX_W'(centre_idx);
		win.up      = line_q[LINE_DEPTH-1];
		win.left    = line_q[LINE_WIDTH];
		win.centre  = line_q[LINE_WIDTH-1];
		win.right   = line_q[LINE_WIDTH-2];
		win.down    = down;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_q[0] <= down;
			for (int k = 1; k < LINE_DEPTH; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= (idx < FRAME_CNT) ? idx + 1'b1 : FRAME_CNT;
		end
	end

endmodule

@@ rtl/core/csl_stencil.sv @@
// Five-point cross averaging arithmetic of the filter.
// Turns a neighborhood bundle into a result item with the grey value in three fields.
// Depends on csl_pkg.
module csl_stencil import csl_pkg::*; (
	input  win_t win,
	output res_t item
);

	logic [PIX_W+1:0] ring_sum;
	logic [PIX_W:0]   mid_sum;
	logic [PIX_W-1:0] grey;

	always_comb begin
		ring_sum = (PIX_W+2)'(win.up) + (PIX_W+2)'(win.left)
			+ (PIX_W+2)'(win.right) + (PIX_W+2)'(win.down);
		mid_sum  = (PIX_W+1)'(ring_sum[PIX_W+1:2]) + (PIX_W+1)'(win.centre);
		grey     = mid_sum[PIX_W:1];
		item.out_index = win.index;
		item.out_rgb   = {grey, grey, grey};
	end

endmodule

@@ rtl/core/csl_out_buf.sv @@
// Result register with one skid entry for the filter's output channel.
// The upstream stall comes straight from the skid flag, so it is registered.
// Depends on csl_pkg.
module csl_out_buf import csl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t item,
	output logic full,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic res_valid_q;
	logic skid_valid_q;
	res_t res_q;
	res_t skid_q;
	logic out_free;

	assign out_free  = !res_valid_q || !res_stall;
	assign full      = skid_valid_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			// While the skid entry is full no new transaction is taken.
			res_valid_q  <= skid_valid_q || load;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			res_q <= skid_valid_q ? skid_q : item;
		end else if (load) begin
			skid_q <= item;
		end
	end

endmodule

@@ rtl/core/cross_stencil_lowpass_filter.sv @@
// Cross stencil low-pass filter over a raster-order pixel stream.
// Input channel pix (pix_valid, pix_stall): one pixel word per transaction;
// only bits 4:0 are used, and frame_start gives the pixel linear index 0.
// Output channel res (res_valid, res_stall): one filtered pixel per result,
// carrying its linear index and the grey value copied into three 5-bit fields.
// The result for centre index c is formed when pixel c+LINE_WIDTH arrives, as
// the average of the centre with the mean of its four cross neighbors;
// neighbors go by linear index, so left and right wrap across row ends.
// Throughput is one pixel per clock while pix_stall is low. When the output is
// free, a result is loaded into the output register driving res at the edge
// that accepts the pixel completing its neighborhood. The first 2*LINE_WIDTH
// pixels of a frame and any pixel beyond FRAME_PIXELS give no result.
// When res_stall holds the output, one more result goes into a skid register
// and pix_stall rises from the next cycle until the output drains.
// Reset clears the pixel index and both result flags; the delay line is not
// cleared, since it is refilled at each frame before any result reads it.
// Depends on csl_pkg, csl_window, csl_stencil and csl_out_buf.
module cross_stencil_lowpass_filter import csl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_stall,
	input  pix_t pix,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	logic accept;
	logic full;
	win_t win;
	res_t item;

	assign pix_stall = full;
	assign accept    = pix_valid && !full;

	csl_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.pix    (pix),
		.win    (win)
	);

	csl_stencil u_stencil (
		.win  (win),
		.item (item)
	);

	csl_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && win.produce),
		.item      (item),
		.full      (full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// The skid entry only fills behind a held output.
	a_skid_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid)
		else $error("skid entry full while output register empty");

	// All three color fields carry the same grey value.
	a_rgb_replicated: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.out_rgb[4:0] == res.out_rgb[9:5])
			&& (res.out_rgb[4:0] == res.out_rgb[14:10]))
		else $error("color fields differ");

	// The first pixel of a frame never completes a neighborhood.
	a_frame_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix_stall && pix.frame_start && !res_valid) |=> !res_valid)
		else $error("result produced for the first pixel of a frame");

	// A held result with a full skid entry blocks the input side.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall && pix_stall) |=> res_valid && pix_stall)
		else $error("stalled results lost or input reopened too early");

endmodule

@@ dv/tb_cross_stencil_lowpass_filter.sv @@
// Self-checking testbench for cross_stencil_lowpass_filter: drives a pixel stream, predicts
// every filtered pixel from its own delay line and index counter, and checks each result.
// Depends on csl_pkg and the filter RTL.
module tb_cross_stencil_lowpass_filter;
	import csl_pkg::*;

	localparam int STUCK_LIMIT  = 1000;
	localparam int LONG_HOLD    = 240;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 200;
	localparam int WIN_LAST     = 2 * LINE_WIDTH;
	localparam int HOLD_FRAME   = 2 * LINE_WIDTH + 10;
	localparam int HOLD_AT      = 2 * LINE_WIDTH + 2;
	localparam int RUN_MAX      = 2 * LINE_WIDTH + 40;
	localparam int TAIL_FRAME   = 2 * LINE_WIDTH + 8;

	typedef enum int {PX_NOISE, PX_EXTREME, PX_DIM} px_style_e;

	typedef struct {
		logic [RAW_W-1:0] word;
		bit               new_frame;
		int               run_len;
		bit               random_px;
		int               grey;      // filtered value known up front, or -1
	} stim_row_t;

	// Flat frames give their own level back, so their result is typed in.
	stim_row_t dir_rows [3] = '{
		'{16'hFFFF, 1'b0,   324, 1'b0, 31},  // after reset, no frame start, all bits set
		'{16'h0000, 1'b1,    40, 1'b1, -1},  // frame cut short before any result
		'{16'h0000, 1'b0,    30, 1'b1, -1}   // the cut frame goes on without a restart
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_t pix = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	logic [PIX_W-1:0] recent_px [0:WIN_LAST];
	int unsigned next_index = 0;
	res_t filtered_px_q [$];

	bit quiet_tail = 1'b0;
	int hold_trigger = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int burst_left = 0;
	int stuck_cycles = 0;

	int mismatch_cnt = 0;
	int results_seen = 0;
	int pixels_sent = 0;
	int frames_started = 0;
	int backpressure_cycles = 0;

	cross_stencil_lowpass_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #4 clk = ~clk;

	// Shift one pixel into the window and queue the filtered pixel it completes.
	task automatic cross_average_predict(input logic [RAW_W-1:0] word, input logic fs,
			input int grey_known);
		int unsigned idx;
		int unsigned sum;
		logic [PIX_W-1:0] grey;
		res_t r;
		idx = fs ? 0 : next_index;
		if (fs) begin
			frames_started++;
		end
		for (int k = WIN_LAST; k > 0; k--) begin
			recent_px[k] = recent_px[k-1];
		end
		recent_px[0] = word[PIX_W-1:0];
		if (idx >= 2 * LINE_WIDTH && idx < FRAME_PIXELS) begin
			sum = 32'(recent_px[LINE_WIDTH+1]) + 32'(recent_px[LINE_WIDTH-1])
				+ 32'(recent_px[WIN_LAST]) + 32'(recent_px[0]);
			sum = (sum >> 2) + 32'(recent_px[LINE_WIDTH]);
			grey = PIX_W'(sum >> 1);
			if (grey_known >= 0) begin
				grey = PIX_W'(grey_known);
			end
			r.out_index = INDEX_W'(idx - LINE_WIDTH);
			r.out_rgb   = {grey, grey, grey};
			filtered_px_q.push_back(r);
		end
		next_index = (idx < FRAME_PIXELS) ? idx + 1 : FRAME_PIXELS;
	endtask

	function automatic logic [RAW_W-1:0] pick_word(input px_style_e style);
		logic [RAW_W-1:0] w;
		w = RAW_W'($urandom);
		case (style)
			PX_EXTREME: begin
				w[PIX_W-1:0] = ($urandom_range(0, 1) != 0) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
			end
			PX_DIM: begin
				w[PIX_W-1:0] = PIX_W'($urandom_range(0, 3));
			end
			default: begin
			end
		endcase
		return w;
	endfunction

	task automatic send_pixel(input logic [RAW_W-1:0] word, input logic fs, input int grey_known);
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= '{pixel_in: word, frame_start: fs};
		do @(posedge clk); while (pix_stall);
		cross_average_predict(word, fs, grey_known);
		pixels_sent++;
	endtask

	task automatic drain_results();
		pix_valid <= 1'b0;
		while (filtered_px_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic log_mismatch(input string what, input int unsigned want_v, input int unsigned got_v);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("Mismatch on %s: expected 0x%0h, got 0x%0h", what, want_v, got_v);
		end
	endtask

	// Result sink: random stall bursts, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_seen != hold_trigger) begin
			hold_seen <= hold_trigger;
			hold_left <= LONG_HOLD;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (burst_left != 0) begin
			burst_left <= burst_left - 1;
			res_stall <= 1'b1;
		end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
			burst_left <= $urandom_range(0, 12);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (filtered_px_q.size() == 0) begin
				log_mismatch("unexpected result index", 0, res.out_index);
			end else begin
				want = filtered_px_q.pop_front();
				if (res.out_index !== want.out_index) begin
					log_mismatch("out_index", want.out_index, res.out_index);
				end
				if (res.out_rgb !== want.out_rgb) begin
					log_mismatch("out_rgb", want.out_rgb, res.out_rgb);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
		if (pix_valid && pix_stall) begin
			backpressure_cycles++;
		end
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles, %0d results outstanding",
				stuck_cycles, filtered_px_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int random_sent;
		int len;
		px_style_e style;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			for (int i = 0; i < dir_rows[r].run_len; i++) begin
				send_pixel(dir_rows[r].random_px ? pick_word(PX_NOISE) : dir_rows[r].word,
					dir_rows[r].new_frame && i == 0, dir_rows[r].grey);
			end
		end

		// Hold the output while pixels keep coming, so the skid fills and the input stalls.
		for (int i = 0; i < HOLD_FRAME; i++) begin
			if (i == HOLD_AT) begin
				hold_trigger <= hold_trigger + 1;
			end
			send_pixel(pick_word(PX_NOISE), i == 0, -1);
		end
		drain_results();

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 2) == 0) begin
				// Broken sequence: short run with stray frame starts.
				len = $urandom_range(1, 40);
				for (int i = 0; i < len; i++) begin
					send_pixel(pick_word(PX_NOISE), $urandom_range(0, 3) == 0, -1);
				end
			end else begin
				len = $urandom_range(2 * LINE_WIDTH + 1, RUN_MAX);
				style = px_style_e'($urandom_range(0, 2));
				for (int i = 0; i < len; i++) begin
					send_pixel(pick_word(style), i == 0, -1);
				end
			end
			random_sent += len;
		end

		// The last frame runs with no idling on either side.
		quiet_tail = 1'b1;
		style = px_style_e'($urandom_range(0, 2));
		for (int i = 0; i < TAIL_FRAME; i++) begin
			send_pixel(pick_word(style), i == 0, -1);
		end
		drain_results();

		$display("Sent %0d pixels over %0d frame starts; checked %0d results.",
			pixels_sent, frames_started, results_seen);
		$display("Input held off in %0d cycles; %0d mismatches.", backpressure_cycles, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ cross_stencil_lowpass_filter.f @@
rtl/core/csl_pkg.sv
rtl/core/csl_window.sv
rtl/core/csl_stencil.sv
rtl/core/csl_out_buf.sv
rtl/core/cross_stencil_lowpass_filter.sv
dv/tb_cross_stencil_lowpass_filter.sv
